FILE: hw/rtl/rv32im_subset_instruction_decoder_assert.svh
// Assertion macros for the instruction decoder.
`ifndef RV32IM_SUBSET_INSTRUCTION_DECODER_ASSERT_SVH
`define RV32IM_SUBSET_INSTRUCTION_DECODER_ASSERT_SVH
`ifndef SYNTH
`define RVDEC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("decoder assertion failed");
`define RVDEC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("decoder assertion failed after reset");
`else
`define RVDEC_ASSERT(lbl, clk, rst, prop)
`define RVDEC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/rvdec_pkg.sv
// Shared types and encoding constants for the instruction decoder.
package rvdec_pkg;

  localparam logic [6:0] OP_RTYPE  = 7'h33;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_ITYPE  = 7'h13;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [31:0] WORD_ECALL = 32'h0000_0073;

  localparam logic [4:0] MN_ADD   = 5'd0;
  localparam logic [4:0] MN_MUL   = 5'd1;
  localparam logic [4:0] MN_SUB   = 5'd2;
  localparam logic [4:0] MN_SLL   = 5'd3;
  localparam logic [4:0] MN_MULH  = 5'd4;
  localparam logic [4:0] MN_SLT   = 5'd5;
  localparam logic [4:0] MN_XOR   = 5'd6;
  localparam logic [4:0] MN_DIV   = 5'd7;
  localparam logic [4:0] MN_SRL   = 5'd8;
  localparam logic [4:0] MN_SRA   = 5'd9;
  localparam logic [4:0] MN_OR    = 5'd10;
  localparam logic [4:0] MN_REM   = 5'd11;
  localparam logic [4:0] MN_AND   = 5'd12;
  localparam logic [4:0] MN_ADDI  = 5'd13;
  localparam logic [4:0] MN_SLLI  = 5'd14;
  localparam logic [4:0] MN_SLTI  = 5'd15;
  localparam logic [4:0] MN_XORI  = 5'd16;
  localparam logic [4:0] MN_SRLI  = 5'd17;
  localparam logic [4:0] MN_SRAI  = 5'd18;
  localparam logic [4:0] MN_ORI   = 5'd19;
  localparam logic [4:0] MN_ANDI  = 5'd20;
  localparam logic [4:0] MN_LB    = 5'd21;
  localparam logic [4:0] MN_LH    = 5'd22;
  localparam logic [4:0] MN_LW    = 5'd23;
  localparam logic [4:0] MN_SB    = 5'd24;
  localparam logic [4:0] MN_SH    = 5'd25;
  localparam logic [4:0] MN_SW    = 5'd26;
  localparam logic [4:0] MN_BEQ   = 5'd27;
  localparam logic [4:0] MN_BNE   = 5'd28;
  localparam logic [4:0] MN_LUI   = 5'd29;
  localparam logic [4:0] MN_JAL   = 5'd30;
  localparam logic [4:0] MN_ECALL = 5'd31;

  typedef struct packed {
    logic               is_valid;
    logic [4:0]         mnemonic;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_one;
    logic [4:0]         src_reg_two;
    logic signed [20:0] immediate;
  } dec_t;

endpackage

FILE: hw/rtl/rvdec_core.sv
// Combinational decode of one instruction word into its result fields.
module rvdec_core (
  input  logic [31:0]         word,
  output rvdec_pkg::dec_t     dec
);
  import rvdec_pkg::*;

  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        hit;
  logic [4:0]  mn;
  logic        use_rd;
  logic        use_rs1;
  logic        use_rs2;
  logic [20:0] imm;
  logic [20:0] imm_i;
  logic [20:0] imm_sh;

  assign opcode = word[6:0];
  assign f3     = word[14:12];
  assign f7     = word[31:25];
  assign imm_i  = {{9{word[31]}}, word[31:20]};
  assign imm_sh = {16'd0, word[24:20]};

  always_comb begin
    hit     = 1'b0;
    mn      = MN_ADD;
    use_rd  = 1'b0;
    use_rs1 = 1'b0;
    use_rs2 = 1'b0;
    imm     = '0;
    unique case (opcode)
      OP_RTYPE: begin
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        hit     = 1'b1;
        priority if (f7 == F7_BASE) begin
          unique case (f3)
            3'd0: mn = MN_ADD;
            3'd1: mn = MN_SLL;
            3'd2: mn = MN_SLT;
            3'd4: mn = MN_XOR;
            3'd5: mn = MN_SRL;
            3'd6: mn = MN_OR;
            3'd7: mn = MN_AND;
            default: hit = 1'b0;
          endcase
        end else if (f7 == F7_MULDIV) begin
          unique case (f3)
            3'd0: mn = MN_MUL;
            3'd1: mn = MN_MULH;
            3'd4: mn = MN_DIV;
            3'd6: mn = MN_REM;
            default: hit = 1'b0;
          endcase
        end else if (f7 == F7_ALT) begin
          unique case (f3)
            3'd0: mn = MN_SUB;
            3'd5: mn = MN_SRA;
            default: hit = 1'b0;
          endcase
        end else begin
          hit = 1'b0;
        end
      end
      OP_ITYPE: begin
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        imm     = imm_i;
        hit     = 1'b1;
        unique case (f3)
          3'd0: mn = MN_ADDI;
          3'd1: begin
            mn  = MN_SLLI;
            imm = imm_sh;
            hit = (f7 == F7_BASE);
          end
          3'd2: mn = MN_SLTI;
          3'd4: mn = MN_XORI;
          3'd5: begin
            mn  = (f7 == F7_ALT) ? MN_SRAI : MN_SRLI;
            imm = imm_sh;
            hit = (f7 == F7_BASE) || (f7 == F7_ALT);
          end
          3'd6: mn = MN_ORI;
          3'd7: mn = MN_ANDI;
          default: hit = 1'b0;
        endcase
      end
      OP_LOAD: begin
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        imm     = imm_i;
        hit     = (f3 <= 3'd2);
        mn      = MN_LB + {3'd0, f3[1:0]};
      end
      OP_STORE: begin
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        imm     = {{9{word[31]}}, word[31:25], word[11:7]};
        hit     = (f3 <= 3'd2);
        mn      = MN_SB + {3'd0, f3[1:0]};
      end
      OP_BRANCH: begin
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        imm     = {{8{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
        hit     = (f3 <= 3'd1);
        mn      = MN_BEQ + {4'd0, f3[0]};
      end
      OP_LUI: begin
        use_rd = 1'b1;
        imm    = {1'b0, word[31:12]};
        hit    = 1'b1;
        mn     = MN_LUI;
      end
      OP_JAL: begin
        use_rd = 1'b1;
        imm    = {word[31], word[19:12], word[20], word[30:21], 1'b0};
        hit    = 1'b1;
        mn     = MN_JAL;
      end
      OP_SYSTEM: begin
        hit = (word == WORD_ECALL);
        mn  = MN_ECALL;
      end
      default: hit = 1'b0;
    endcase
  end

  // An unsupported word clears every field, not only the valid flag.
  always_comb begin
    dec = '0;
    if (hit) begin
      dec.is_valid    = 1'b1;
      dec.mnemonic    = mn;
      dec.dest_reg    = use_rd  ? word[11:7]  : 5'd0;
      dec.src_reg_one = use_rs1 ? word[19:15] : 5'd0;
      dec.src_reg_two = use_rs2 ? word[24:20] : 5'd0;
      dec.immediate   = imm;
    end
  end

endmodule

FILE: hw/rtl/rvdec_out_reg.sv
// Result register stage with a stream handshake towards the output.
module rvdec_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rvdec_pkg::dec_t in_dec,
  output logic            out_valid,
  input  logic            out_ready,
  output rvdec_pkg::dec_t out_dec
);
  import rvdec_pkg::*;

  dec_t held;
  logic full;

  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_dec   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_dec;
    end
  end

endmodule

FILE: hw/rtl/rv32im_subset_instruction_decoder.sv
// Top level of the RV32IM subset instruction decoder.
//
//  channel  | direction | tdata fields (low bit first)
//  s_*      | in        | instruction_word[31:0]
//  m_*      | out       | is_valid, mnemonic, dest_reg, src_reg_one, src_reg_two, immediate
//
// One word is accepted every cycle while the output is not stalled; each result passes
// through the input register, the decode logic and the result register, in that order.
// A synchronous reset empties both registers.
// A stall at the output holds the result; the input register keeps taking words
// until both registers are full.
module rv32im_subset_instruction_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // instruction_word[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // is_valid[0], mnemonic[5:1], dest_reg[10:6],
                                 // src_reg_one[15:11], src_reg_two[20:16],
                                 // immediate[41:21], zero[47:42]
);
  import rvdec_pkg::*;

  logic [31:0] word;
  logic        word_valid;
  logic        res_ready;
  dec_t        dec;
  dec_t        res;

  assign s_tready = !word_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (s_tready) begin
      word_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      word <= s_tdata;
    end
  end

  rvdec_core u_core (
    .word (word),
    .dec  (dec)
  );

  rvdec_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (word_valid),
    .in_ready  (res_ready),
    .in_dec    (dec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_dec   (res)
  );

  assign m_tdata = {6'd0, res.immediate, res.src_reg_two, res.src_reg_one,
                    res.dest_reg, res.mnemonic, res.is_valid};

`include "rv32im_subset_instruction_decoder_assert.svh"

  // With the result register empty the input side can never be stalled.
  `RVDEC_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready)
  // A rejected word leaves every result field cleared.
  `RVDEC_ASSERT(a_invalid_clear, clk, rst, (m_tvalid && !res.is_valid) |-> (res == '0))
  // The lui value is unsigned, so its top bit stays clear.
  `RVDEC_ASSERT(a_lui_unsigned, clk, rst,
    (m_tvalid && res.is_valid && res.mnemonic == MN_LUI) |-> !res.immediate[20])
  // Nothing is presented in the cycle after reset.
  `RVDEC_ASSERT_NORST(a_empty_after_reset, clk, $past(rst) |-> (!m_tvalid && !word_valid))

endmodule

FILE: verif/tb_rv32im_subset_instruction_decoder.sv
// Self-checking stream testbench for the RV32IM subset instruction decoder.
module tb_rv32im_subset_instruction_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import rvdec_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [31:0] word;
    dec_t        decoded;
  } pending_decode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  pending_decode_t pending_decodes[$];
  int          sender_idle_pct    = 0;
  int          receiver_stall_pct = 0;
  int          error_count        = 0;
  int          words_sent         = 0;
  int          valid_results      = 0;
  int          invalid_results    = 0;
  logic [31:0] mnemonics_seen     = '0;

  rv32im_subset_instruction_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10ns clk = ~clk;

  // Expected decode of one instruction word.
  function automatic dec_t decode_word(input logic [31:0] w);
    dec_t        d;
    logic        ok;
    logic        use_rd;
    logic        use_rs1;
    logic        use_rs2;
    logic [4:0]  mn;
    logic [20:0] imm;
    logic [6:0]  f7;
    logic [2:0]  f3;
    f7      = w[31:25];
    f3      = w[14:12];
    ok      = 1'b1;
    use_rd  = 1'b0;
    use_rs1 = 1'b0;
    use_rs2 = 1'b0;
    mn      = '0;
    imm     = '0;
    case (w[6:0])
      OP_RTYPE: begin
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        case ({f7, f3})
          {F7_BASE, 3'd0}:   mn = MN_ADD;
          {F7_MULDIV, 3'd0}: mn = MN_MUL;
          {F7_ALT, 3'd0}:    mn = MN_SUB;
          {F7_BASE, 3'd1}:   mn = MN_SLL;
          {F7_MULDIV, 3'd1}: mn = MN_MULH;
          {F7_BASE, 3'd2}:   mn = MN_SLT;
          {F7_BASE, 3'd4}:   mn = MN_XOR;
          {F7_MULDIV, 3'd4}: mn = MN_DIV;
          {F7_BASE, 3'd5}:   mn = MN_SRL;
          {F7_ALT, 3'd5}:    mn = MN_SRA;
          {F7_BASE, 3'd6}:   mn = MN_OR;
          {F7_MULDIV, 3'd6}: mn = MN_REM;
          {F7_BASE, 3'd7}:   mn = MN_AND;
          default:           ok = 1'b0;
        endcase
      end
      OP_ITYPE: begin
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        imm     = {{9{w[31]}}, w[31:20]};
        case (f3)
          3'd0: mn = MN_ADDI;
          3'd1: begin
            mn  = MN_SLLI;
            ok  = (f7 == F7_BASE);
            imm = {16'b0, w[24:20]};
          end
          3'd2: mn = MN_SLTI;
          3'd4: mn = MN_XORI;
          3'd5: begin
            mn  = (f7 == F7_ALT) ? MN_SRAI : MN_SRLI;
            ok  = (f7 == F7_BASE) || (f7 == F7_ALT);
            imm = {16'b0, w[24:20]};
          end
          3'd6: mn = MN_ORI;
          3'd7: mn = MN_ANDI;
          default: ok = 1'b0;
        endcase
      end
      OP_LOAD: begin
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        imm     = {{9{w[31]}}, w[31:20]};
        ok      = (f3 <= 3'd2);
        mn      = 5'(MN_LB + f3);
      end
      OP_STORE: begin
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        imm     = {{9{w[31]}}, w[31:25], w[11:7]};
        ok      = (f3 <= 3'd2);
        mn      = 5'(MN_SB + f3);
      end
      OP_BRANCH: begin
        use_rs1 = 1'b1;
        use_rs2 = 1'b1;
        imm     = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        ok      = (f3 <= 3'd1);
        mn      = 5'(MN_BEQ + f3);
      end
      OP_LUI: begin
        use_rd = 1'b1;
        imm    = {1'b0, w[31:12]};
        mn     = MN_LUI;
      end
      OP_JAL: begin
        use_rd = 1'b1;
        imm    = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        mn     = MN_JAL;
      end
      OP_SYSTEM: begin
        ok = (w == WORD_ECALL);
        mn = MN_ECALL;
      end
      default: ok = 1'b0;
    endcase
    d = '0;
    if (ok) begin
      d.is_valid    = 1'b1;
      d.mnemonic    = mn;
      d.dest_reg    = use_rd ? w[11:7] : 5'd0;
      d.src_reg_one = use_rs1 ? w[19:15] : 5'd0;
      d.src_reg_two = use_rs2 ? w[24:20] : 5'd0;
      d.immediate   = imm;
    end
    return d;
  endfunction

  // Builds a well-formed word for one mnemonic; the free fields come from fill.
  function automatic logic [31:0] encode_op(input logic [4:0] mn, input logic [31:0] fill);
    logic [31:0] w;
    w = fill;
    case (mn)
      MN_ADD:   {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd0, OP_RTYPE};
      MN_MUL:   {w[31:25], w[14:12], w[6:0]} = {F7_MULDIV, 3'd0, OP_RTYPE};
      MN_SUB:   {w[31:25], w[14:12], w[6:0]} = {F7_ALT, 3'd0, OP_RTYPE};
      MN_SLL:   {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd1, OP_RTYPE};
      MN_MULH:  {w[31:25], w[14:12], w[6:0]} = {F7_MULDIV, 3'd1, OP_RTYPE};
      MN_SLT:   {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd2, OP_RTYPE};
      MN_XOR:   {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd4, OP_RTYPE};
      MN_DIV:   {w[31:25], w[14:12], w[6:0]} = {F7_MULDIV, 3'd4, OP_RTYPE};
      MN_SRL:   {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd5, OP_RTYPE};
      MN_SRA:   {w[31:25], w[14:12], w[6:0]} = {F7_ALT, 3'd5, OP_RTYPE};
      MN_OR:    {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd6, OP_RTYPE};
      MN_REM:   {w[31:25], w[14:12], w[6:0]} = {F7_MULDIV, 3'd6, OP_RTYPE};
      MN_AND:   {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd7, OP_RTYPE};
      MN_ADDI:  {w[14:12], w[6:0]} = {3'd0, OP_ITYPE};
      MN_SLLI:  {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd1, OP_ITYPE};
      MN_SLTI:  {w[14:12], w[6:0]} = {3'd2, OP_ITYPE};
      MN_XORI:  {w[14:12], w[6:0]} = {3'd4, OP_ITYPE};
      MN_SRLI:  {w[31:25], w[14:12], w[6:0]} = {F7_BASE, 3'd5, OP_ITYPE};
      MN_SRAI:  {w[31:25], w[14:12], w[6:0]} = {F7_ALT, 3'd5, OP_ITYPE};
      MN_ORI:   {w[14:12], w[6:0]} = {3'd6, OP_ITYPE};
      MN_ANDI:  {w[14:12], w[6:0]} = {3'd7, OP_ITYPE};
      MN_LB:    {w[14:12], w[6:0]} = {3'd0, OP_LOAD};
      MN_LH:    {w[14:12], w[6:0]} = {3'd1, OP_LOAD};
      MN_LW:    {w[14:12], w[6:0]} = {3'd2, OP_LOAD};
      MN_SB:    {w[14:12], w[6:0]} = {3'd0, OP_STORE};
      MN_SH:    {w[14:12], w[6:0]} = {3'd1, OP_STORE};
      MN_SW:    {w[14:12], w[6:0]} = {3'd2, OP_STORE};
      MN_BEQ:   {w[14:12], w[6:0]} = {3'd0, OP_BRANCH};
      MN_BNE:   {w[14:12], w[6:0]} = {3'd1, OP_BRANCH};
      MN_LUI:   w[6:0] = OP_LUI;
      MN_JAL:   w[6:0] = OP_JAL;
      default:  w = WORD_ECALL;
    endcase
    return w;
  endfunction

  // Mostly well-formed words; the rest have a broken funct field, a near-ecall or are noise.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          pick;
    w    = encode_op(5'($urandom_range(31)), $urandom());
    pick = $urandom_range(99);
    if (pick < 8)
      w[31:25] = 7'($urandom());
    else if (pick < 12)
      w[14:12] = 3'($urandom());
    else if (pick < 15)
      w = WORD_ECALL ^ (32'h1 << $urandom_range(31, 7));
    else if (pick < 20)
      w = $urandom();
    return w;
  endfunction

  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_decodes.push_back('{word: w, decoded: decode_word(w)});
    words_sent++;
  endtask

  // Holds the sender off until every outstanding word has been decoded.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int want, input int seen,
                               input logic [31:0] word);
    if (want !== seen) begin
      $error("word %h: %s expected %0d, got %0d", word, name, want, seen);
      error_count++;
    end
  endtask

  task automatic check_result(input logic [47:0] data);
    pending_decode_t item;
    if (pending_decodes.size() == 0) begin
      $error("result word %h arrived with no instruction outstanding", data);
      error_count++;
      return;
    end
    item = pending_decodes.pop_front();
    compare_field("is_valid", item.decoded.is_valid, data[0], item.word);
    compare_field("mnemonic", item.decoded.mnemonic, data[5:1], item.word);
    compare_field("dest_reg", item.decoded.dest_reg, data[10:6], item.word);
    compare_field("src_reg_one", item.decoded.src_reg_one, data[15:11], item.word);
    compare_field("src_reg_two", item.decoded.src_reg_two, data[20:16], item.word);
    compare_field("immediate", item.decoded.immediate, $signed(data[41:21]), item.word);
    compare_field("padding", 0, data[47:42], item.word);
    if (item.decoded.is_valid) begin
      valid_results++;
      mnemonics_seen[item.decoded.mnemonic] = 1'b1;
    end else begin
      invalid_results++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $error("no word moved on either side for %0d cycles", WATCHDOG_LIMIT);
    $display("rv32im_subset_instruction_decoder regression: fail");
    $finish;
  end

  // Every mnemonic once, alternating all-zero and all-one free fields.
  task automatic test_every_operation();
    for (int mn = 0; mn < 32; mn++)
      send_word(encode_op(5'(mn), mn[0] ? 32'hFFFF_FFFF : 32'h0000_0000));
  endtask

  task automatic test_field_extremes();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    // Most negative I immediate and the widest positive jump.
    send_word({12'h800, 5'd31, 3'd0, 5'd31, OP_ITYPE});
    send_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd31, OP_JAL});
    send_word({1'b1, 10'h000, 1'b0, 8'h00, 5'd0, OP_JAL});
  endtask

  task automatic test_special_cases();
    // R-type funct7 values that are not listed for their funct3.
    send_word({F7_MULDIV, 5'd3, 5'd4, 3'd2, 5'd5, OP_RTYPE});
    send_word({F7_ALT, 5'd3, 5'd4, 3'd7, 5'd5, OP_RTYPE});
    send_word({7'h7F, 5'd1, 5'd2, 3'd0, 5'd3, OP_RTYPE});
    send_word({F7_BASE, 5'd1, 5'd2, 3'd3, 5'd3, OP_RTYPE});
    // Shift immediates with the wrong upper bits, a legal srai and an unused I-type funct3.
    send_word({F7_ALT, 5'd7, 5'd1, 3'd1, 5'd2, OP_ITYPE});
    send_word({F7_MULDIV, 5'd7, 5'd1, 3'd5, 5'd2, OP_ITYPE});
    send_word({F7_ALT, 5'd31, 5'd9, 3'd5, 5'd10, OP_ITYPE});
    send_word({12'h123, 5'd1, 3'd3, 5'd2, OP_ITYPE});
    // Only the exact ecall word is accepted on the system opcode.
    send_word(WORD_ECALL | 32'h0000_0080);
    send_word(WORD_ECALL | 32'h0010_0000);
    // funct3 values outside the load, store and branch subsets.
    send_word({12'h7FF, 5'd1, 3'd3, 5'd2, OP_LOAD});
    send_word({7'h00, 5'd1, 5'd2, 3'd4, 5'd3, OP_STORE});
    send_word({7'h00, 5'd1, 5'd2, 3'd2, 5'd3, OP_BRANCH});
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      send_word(random_word());
    end
    wait_for_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_every_operation();
    test_field_extremes();
    test_special_cases();
    wait_for_results();
    test_random_phase(0, 0, 312);
    test_random_phase(60, 0, 313);
    test_random_phase(0, 60, 313);
    test_random_phase(24, 24, 312);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Decoded %0d instruction words: %0d valid, %0d invalid, %0d of 32 mnemonics hit,",
             words_sent, valid_results, invalid_results, $countones(mnemonics_seen));
    $display("under free-running, sender-idle, receiver-stall and mixed pacing.");
    if (error_count == 0)
      $display("rv32im_subset_instruction_decoder regression: pass");
    else
      $display("rv32im_subset_instruction_decoder regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rvdec_pkg.sv
hw/rtl/rvdec_core.sv
hw/rtl/rvdec_out_reg.sv
hw/rtl/rv32im_subset_instruction_decoder.sv
verif/tb_rv32im_subset_instruction_decoder.sv
